@@ rtl/qdd_pkg.sv @@
package qdd_pkg;

	localparam int SampleW  = 32;
	localparam int PendingW = 32;
	localparam int MaskW    = 32;
	localparam int TdataOutW = 40;

	// phase codes
	localparam logic [2:0] PH_UNKNOWN = 3'd0;
	localparam logic [2:0] PH_REST_A  = 3'd1;
	localparam logic [2:0] PH_CW_A    = 3'd2;
	localparam logic [2:0] PH_CCW_A   = 3'd3;
	localparam logic [2:0] PH_REST_B  = 3'd4;
	localparam logic [2:0] PH_CW_B    = 3'd5;
	localparam logic [2:0] PH_CCW_B   = 3'd6;

	// phase patterns, A in bit 0 and B in bit 1
	localparam logic [1:0] PAT_00 = 2'b00;
	localparam logic [1:0] PAT_A  = 2'b01;
	localparam logic [1:0] PAT_B  = 2'b10;
	localparam logic [1:0] PAT_AB = 2'b11;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COMMIT = 1'b1;

	localparam logic CFG_A_MASK = 1'b0;
	localparam logic CFG_B_MASK = 1'b1;

	localparam logic [MaskW-1:0] A_MASK_RESET = 32'h0000_0001;
	localparam logic [MaskW-1:0] B_MASK_RESET = 32'h0000_0002;

	localparam logic signed [1:0] DELTA_NONE = 2'sb00;
	localparam logic signed [1:0] DELTA_CW   = 2'sb01;
	localparam logic signed [1:0] DELTA_CCW  = 2'sb11;

	typedef struct packed {
		logic [2:0]        next;
		logic signed [1:0] delta;
	} trans_t;

	typedef struct packed {
		logic                      moved;
		logic signed [1:0]         step;
		logic signed [PendingW-1:0] pending;
	} result_t;

	function automatic trans_t phase_step(input logic [2:0] cur, input logic [1:0] pat);
		trans_t t;
		t.delta = DELTA_NONE;
		t.next  = PH_UNKNOWN;
		unique case (pat)
			PAT_00: t.next = PH_REST_A;
			PAT_AB: t.next = PH_REST_B;
			PAT_A: begin
				unique case (cur)
					PH_REST_A, PH_CW_A: t.next = PH_CW_A;
					PH_REST_B, PH_CCW_B: t.next = PH_CCW_B;
					default: t.next = PH_UNKNOWN;
				endcase
			end
			PAT_B: begin
				unique case (cur)
					PH_REST_A, PH_CCW_A: t.next = PH_CCW_A;
					PH_REST_B, PH_CW_B: t.next = PH_CW_B;
					default: t.next = PH_UNKNOWN;
				endcase
			end
		endcase
		// a detent completes on arrival at the opposite rest state
		if (pat == PAT_AB && cur == PH_CW_A) t.delta = DELTA_CW;
		if (pat == PAT_AB && cur == PH_CCW_A) t.delta = DELTA_CCW;
		if (pat == PAT_00 && cur == PH_CW_B) t.delta = DELTA_CW;
		if (pat == PAT_00 && cur == PH_CCW_B) t.delta = DELTA_CCW;
		return t;
	endfunction

endpackage

@@ rtl/quadrature_detent_decoder.sv @@
// Quadrature detent decoder: phase table step and detent count per request.
// A request is held in the input register, then moves to the result register
// once that register is free.
// Throughput: one request per cycle while m_tready keeps the result register free;
// the phase table step and one 32-bit add sit between the two registers.
// Reset: masks return to 1 and 2, phase unknown, pending change zero, no request held.
module quadrature_detent_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [qdd_pkg::MaskW-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [qdd_pkg::SampleW-1:0]     s_tdata,   // sample_word
	input  logic                            s_tuser,   // kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [qdd_pkg::TdataOutW-1:0]   m_tdata    // moved, step[1:0], pending_change[31:0]
);
	import qdd_pkg::*;

	logic [MaskW-1:0]   a_mask_q;
	logic [MaskW-1:0]   b_mask_q;
	logic               valid_s1;
	logic               kind_s1;
	logic [SampleW-1:0] sample_s1;
	logic               out_valid_q;
	result_t            out_q;
	result_t            result;
	logic               advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_mask_q <= A_MASK_RESET;
			b_mask_q <= B_MASK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_A_MASK: a_mask_q <= cfg_wdata;
				CFG_B_MASK: b_mask_q <= cfg_wdata;
			endcase
		end
	end

	// move the held request into the result register whenever that slot frees
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= s_tuser;
			sample_s1 <= s_tdata;
		end
	end

	qdd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.kind   (kind_s1),
		.sample (sample_s1),
		.a_mask (a_mask_q),
		.b_mask (b_mask_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TdataOutW-PendingW-3){1'b0}}, out_q.pending, out_q.step, out_q.moved};

endmodule

@@ rtl/qdd_core.sv @@
module qdd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          kind,
	input  logic [qdd_pkg::SampleW-1:0]   sample,
	input  logic [qdd_pkg::MaskW-1:0]     a_mask,
	input  logic [qdd_pkg::MaskW-1:0]     b_mask,
	output qdd_pkg::result_t              result
);
	import qdd_pkg::*;

	logic [2:0]                phase_q;
	logic signed [PendingW-1:0] pending_q;
	logic [1:0]                pat;
	trans_t                    trans;
	logic signed [PendingW-1:0] pending_next;

	assign pat   = {|(sample & b_mask), |(sample & a_mask)};
	assign trans = phase_step(phase_q, pat);

	// position minus baseline is all that is ever reported, so track it directly
	always_comb begin
		if (kind == KIND_COMMIT) begin
			pending_next   = '0;
			result.moved   = 1'b0;
			result.step    = DELTA_NONE;
		end else begin
			pending_next   = pending_q + {{(PendingW-2){trans.delta[1]}}, trans.delta};
			result.moved   = (trans.delta != DELTA_NONE);
			result.step    = trans.delta;
		end
		result.pending = pending_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_UNKNOWN;
			pending_q <= '0;
		end else if (en) begin
			pending_q <= pending_next;
			if (kind == KIND_SAMPLE) phase_q <= trans.next;
		end
	end

endmodule
